// ----- design/nos_pkg.sv -----
// ----------------------------------------------------------------------------
// Outlier smoother package
// Shared widths, reset values, register indexes and divider constants for
// the neighbourhood outlier smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package nos_pkg;

    // Field widths
    localparam int PIX_W        = 4;
    localparam int CFG_WIDTH_W  = 6;
    localparam int CFG_HEIGHT_W = 11;
    localparam int THR_W        = 4;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int SUM_W        = 8;

    // Default sizing of the line store and row counter
    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIFF_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RST    = 6'd30;
    localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RST   = 11'd20;
    localparam logic [THR_W-1:0]        DIFF_THRESHOLD_RST = 4'd1;

    // Window position classes, which fix the divisor of the mean
    localparam logic [1:0] KIND_INNER  = 2'd0;  // nine values
    localparam logic [1:0] KIND_EDGE   = 2'd1;  // six values
    localparam logic [1:0] KIND_CORNER = 2'd2;  // four values

    // Reciprocals: floor(x/6) = (x*43)>>8 for x <= 90,
    // floor(x/9) = (x*57)>>9 for x <= 135.
    localparam int RECIP_W       = 6;
    localparam int PROD_W        = SUM_W + RECIP_W;
    localparam int RECIP_6       = 43;
    localparam int RECIP_6_SHIFT = 8;
    localparam int RECIP_9       = 57;
    localparam int RECIP_9_SHIFT = 9;

    // Position of the pixel being emitted within the frame
    typedef struct packed {
        logic top_edge;
        logic bottom_edge;
        logic left_edge;
        logic right_edge;
        logic emit;
        logic run_last;
    } pos_flags_t;

endpackage

`default_nettype wire

// ----- design/nos_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module nos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/neighbourhood_outlier_smoother.sv -----
// ----------------------------------------------------------------------------
// Neighbourhood outlier smoother
// 3x3 despeckle filter: a pixel that differs from every existing neighbour
// by more than a threshold is replaced by the truncated mean of its window.
// ----------------------------------------------------------------------------
// Usage. Pixels of a frame enter in raster order on the s_ channel, one item
// per cycle when nothing stalls, gray level in s_tdata[3:0]. Filtered
// pixels leave in raster order on the m_ channel. Each result trails its
// source by one row plus one pixel, so the first row of a frame and the
// first pixel of the second row produce no result at all. Accepting the
// final pixel of a frame starts a flush: the block issues width plus one
// flush items that read back the two stored rows and emit the remaining
// results, and s_tready stays low meanwhile. An item passes through three
// register stages (line store read and input register, window register,
// sum register) before the output register. Sustained rate is one item
// per cycle when nothing stalls, set by the single read and write port of
// the line store; the frame flush holds off new input while it runs.
// When the receiver stalls, each stage holds its item and the stall walks
// back to s_tready stage by stage; empty stages still take new items.
// Reset clears all valid flags, the position counters and the flush, and
// loads the registers with width 30, height 20 and threshold 1. Any write
// to a valid register index restarts the frame at its first pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbourhood_outlier_smoother
    import nos_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    // Input pixels
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [3:0] pixel_in, [7:4] zero

    // Filtered pixels
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [7:0]             m_tdata,   // [3:0] pixel_out, [7:4] zero
    output logic                        m_tlast,   // run_last
    output logic      [1:0]             m_tuser,   // [0] was_replaced, [1] frame_end

    // Register writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Column index and flush counter width; the usable width is at most
    // MAX_WIDTH-1, so both fit. Row counter holds at most MAX_HEIGHT-1.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [THR_W-1:0]        thr_reg;
    logic                    cfg_wr;
    logic                    cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && ((cfg_index == REG_FRAME_WIDTH) ||
                                  (cfg_index == REG_FRAME_HEIGHT) ||
                                  (cfg_index == REG_DIFF_THRESHOLD));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
            thr_reg    <= DIFF_THRESHOLD_RST;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_FRAME_WIDTH:    width_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                REG_FRAME_HEIGHT:   height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
                REG_DIFF_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective frame size: width clamped to 2..MAX_WIDTH-1, height to
    // 2..MAX_HEIGHT. Held as the index of the last column and row.
    logic [31:0]   w_cfg32;
    logic [31:0]   h_cfg32;
    logic [31:0]   w_clamp32;
    logic [31:0]   h_clamp32;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;

    assign w_cfg32 = {{(32-CFG_WIDTH_W){1'b0}}, width_reg};
    assign h_cfg32 = {{(32-CFG_HEIGHT_W){1'b0}}, height_reg};

    always_comb begin
        if (w_cfg32 < 32'd2) begin
            w_clamp32 = 32'd2;
        end else if (w_cfg32 > 32'(MAX_WIDTH - 1)) begin
            w_clamp32 = 32'(MAX_WIDTH - 1);
        end else begin
            w_clamp32 = w_cfg32;
        end
        if (h_cfg32 < 32'd2) begin
            h_clamp32 = 32'd2;
        end else if (h_cfg32 > 32'(MAX_HEIGHT)) begin
            h_clamp32 = 32'(MAX_HEIGHT);
        end else begin
            h_clamp32 = h_cfg32;
        end
    end

    assign w_eff  = w_clamp32[CW-1:0];
    assign w_last = CW'(w_clamp32 - 32'd1);
    assign h_last = RW'(h_clamp32 - 32'd1);

    // ------------------------------------------------------------------
    // Pipeline handshakes. Stage A: input register and line store read.
    // Stage B: window. Stage C: sum and outlier decision. Then output.
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic m_valid_reg;
    pos_flags_t b_flags_reg;

    logic out_ready_in;
    logic c_ready_in;
    logic c_leave;
    logic b_leave;
    logic b_ready_in;
    logic a_leave;
    logic a_ready_in;
    logic a_load;
    logic s_accept;
    logic flush_issue;

    logic          flush_active_reg;
    logic [CW-1:0] fcount_reg;

    assign out_ready_in = !m_valid_reg || m_tready;
    assign c_ready_in   = !c_valid_reg || out_ready_in;
    assign c_leave      = c_valid_reg && out_ready_in;
    // Items that emit nothing still shift the window, then vanish here.
    assign b_leave      = b_valid_reg && (!b_flags_reg.emit || c_ready_in);
    assign b_ready_in   = !b_valid_reg || b_leave;
    assign a_leave      = a_valid_reg && b_ready_in;
    assign a_ready_in   = !a_valid_reg || b_ready_in;

    assign s_tready    = a_ready_in && !flush_active_reg;
    assign s_accept    = s_tvalid && s_tready;
    assign flush_issue = flush_active_reg && a_ready_in;
    assign a_load      = s_accept || flush_issue;

    // ------------------------------------------------------------------
    // Position counters and frame flush sequencer
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic          last_px;

    assign last_px = (row_reg == h_last) && (col_reg == w_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg          <= '0;
            row_reg          <= '0;
            flush_active_reg <= 1'b0;
            fcount_reg       <= '0;
        end else if (cfg_hit) begin
            col_reg          <= '0;
            row_reg          <= '0;
            flush_active_reg <= 1'b0;
            fcount_reg       <= '0;
        end else begin
            if (s_accept) begin
                if (last_px) begin
                    col_reg          <= '0;
                    row_reg          <= '0;
                    flush_active_reg <= 1'b1;
                    fcount_reg       <= '0;
                end else if (col_reg == w_last) begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (flush_issue) begin
                if (fcount_reg == w_eff) begin
                    flush_active_reg <= 1'b0;
                end else begin
                    fcount_reg <= fcount_reg + CW'(1);
                end
            end
        end
    end

    // Where the pixel emitted after this column shift sits in the frame.
    // A normal item emits the pixel one row plus one pixel behind it in
    // raster order; flush items emit the pixels still owed from the last two
    // rows, and the final flush item emits the bottom right corner.
    pos_flags_t in_flags;
    logic       col_nz;
    logic       fc_nz;

    always_comb begin
        col_nz   = (col_reg != '0);
        fc_nz    = (fcount_reg != '0);
        in_flags = '0;
        if (flush_active_reg) begin
            if (fcount_reg == w_eff) begin
                in_flags.bottom_edge = 1'b1;
                in_flags.right_edge  = 1'b1;
                in_flags.emit        = 1'b1;
                in_flags.run_last    = 1'b1;
            end else begin
                in_flags.top_edge    = !fc_nz && (h_last == RW'(1));
                in_flags.bottom_edge = fc_nz;
                in_flags.left_edge   = (fcount_reg == CW'(1));
                in_flags.right_edge  = !fc_nz;
                in_flags.emit        = 1'b1;
            end
        end else begin
            in_flags.top_edge   = col_nz ? (row_reg == RW'(1)) : (row_reg == RW'(2));
            in_flags.left_edge  = (col_reg == CW'(1));
            in_flags.right_edge = !col_nz;
            in_flags.emit       = (row_reg != '0) && !((row_reg == RW'(1)) && !col_nz);
            in_flags.run_last   = in_flags.emit && !last_px;
        end
    end

    // ------------------------------------------------------------------
    // Stage A and the line store. Each entry holds the column's pixel two
    // rows up (upper half) and one row up (lower half).
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]   a_pix_reg;
    logic [CW-1:0]      a_col_reg;
    logic               a_wr_reg;
    pos_flags_t         a_flags_reg;
    logic [CW-1:0]      rd_addr;
    logic [2*PIX_W-1:0] rd_data;
    logic [PIX_W-1:0]   rd_up;
    logic [PIX_W-1:0]   rd_md;

    assign rd_addr = flush_active_reg ? fcount_reg : col_reg;
    assign rd_up   = rd_data[2*PIX_W-1:PIX_W];
    assign rd_md   = rd_data[PIX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_load) begin
            a_valid_reg <= 1'b1;
        end else if (a_leave) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_pix_reg   <= flush_active_reg ? '0 : s_tdata[PIX_W-1:0];
            a_col_reg   <= col_reg;
            a_wr_reg    <= !flush_active_reg;
            a_flags_reg <= in_flags;
        end
    end

    nos_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (aclk),
        .we    (a_leave && a_wr_reg),
        .waddr (a_col_reg),
        .wdata ({rd_md, a_pix_reg}),
        .re    (a_load),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // Stage B: the 3x3 window of original pixels, row 0 on top, column 2
    // the newest. It shifts once for every item that leaves stage A.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_reg [3][3];
    logic [PIX_W-1:0] new_col [3];

    assign new_col[0] = rd_up;
    assign new_col[1] = rd_md;
    assign new_col[2] = a_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_leave) begin
            b_valid_reg <= 1'b1;
        end else if (b_leave) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_leave) begin
            b_flags_reg <= a_flags_reg;
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
                win_reg[i][2] <= new_col[i];
            end
        end
    end

    // Neighbours outside the frame are masked out of both the outlier
    // test and the sum; a pixel is an outlier only when no existing
    // neighbour lies within the threshold.
    logic [PIX_W-1:0] ctr;
    logic [SUM_W-1:0] win_sum;
    logic             any_close;
    logic [1:0]       win_kind;
    logic             nb_ok;
    logic [PIX_W-1:0] nb;
    logic [PIX_W-1:0] diff;

    always_comb begin
        ctr       = win_reg[1][1];
        win_sum   = {{(SUM_W-PIX_W){1'b0}}, ctr};
        any_close = 1'b0;
        nb_ok     = 1'b0;
        nb        = '0;
        diff      = '0;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                nb    = win_reg[dr][dc];
                nb_ok = !((dr == 1) && (dc == 1)) &&
                        !((dr == 0) && b_flags_reg.top_edge) &&
                        !((dr == 2) && b_flags_reg.bottom_edge) &&
                        !((dc == 0) && b_flags_reg.left_edge) &&
                        !((dc == 2) && b_flags_reg.right_edge);
                diff  = (ctr > nb) ? (ctr - nb) : (nb - ctr);
                if (nb_ok) begin
                    win_sum = win_sum + {{(SUM_W-PIX_W){1'b0}}, nb};
                    if (diff <= thr_reg) begin
                        any_close = 1'b1;
                    end
                end
            end
        end
        if ((b_flags_reg.top_edge || b_flags_reg.bottom_edge) &&
            (b_flags_reg.left_edge || b_flags_reg.right_edge)) begin
            win_kind = KIND_CORNER;
        end else if (b_flags_reg.top_edge || b_flags_reg.bottom_edge ||
                     b_flags_reg.left_edge || b_flags_reg.right_edge) begin
            win_kind = KIND_EDGE;
        end else begin
            win_kind = KIND_INNER;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: sum, centre pixel and decision
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] c_sum_reg;
    logic [PIX_W-1:0] c_ctr_reg;
    logic             c_outlier_reg;
    logic [1:0]       c_kind_reg;
    logic             c_frame_end_reg;
    logic             c_run_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (b_leave && b_flags_reg.emit) begin
            c_valid_reg <= 1'b1;
        end else if (c_leave) begin
            c_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_leave && b_flags_reg.emit) begin
            c_sum_reg       <= win_sum;
            c_ctr_reg       <= ctr;
            c_outlier_reg   <= !any_close;
            c_kind_reg      <= win_kind;
            c_frame_end_reg <= b_flags_reg.bottom_edge && b_flags_reg.right_edge;
            c_run_last_reg  <= b_flags_reg.run_last;
        end
    end

    // Truncated mean by reciprocal multiplication; the sums stay small
    // enough for these reciprocals to be exact.
    logic [PROD_W-1:0] prod_6;
    logic [PROD_W-1:0] prod_9;
    logic [PROD_W-1:0] quot;
    logic [PIX_W-1:0]  mean;

    assign prod_6 = PROD_W'(c_sum_reg) * PROD_W'(RECIP_6);
    assign prod_9 = PROD_W'(c_sum_reg) * PROD_W'(RECIP_9);

    always_comb begin
        case (c_kind_reg)
            KIND_CORNER: quot = PROD_W'(c_sum_reg) >> 2;
            KIND_EDGE:   quot = prod_6 >> RECIP_6_SHIFT;
            KIND_INNER:  quot = prod_9 >> RECIP_9_SHIFT;
            default:     quot = '0;
        endcase
        mean = quot[PIX_W-1:0];
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] m_pix_reg;
    logic             m_replaced_reg;
    logic             m_last_reg;
    logic             m_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (c_leave) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_leave) begin
            m_pix_reg       <= c_outlier_reg ? mean : c_ctr_reg;
            m_replaced_reg  <= c_outlier_reg;
            m_last_reg      <= c_run_last_reg;
            m_frame_end_reg <= c_frame_end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8-PIX_W){1'b0}}, m_pix_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_frame_end_reg, m_replaced_reg};

`ifndef SYNTHESIS
    // The frame's final pixel is always the last result of its flush.
    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("frame end result without tlast");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= w_last)
        else $error("column counter beyond frame width");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= h_last)
        else $error("row counter beyond frame height");

    a_flush_range: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_active_reg |-> (fcount_reg <= w_eff))
        else $error("flush counter ran past the row");
`endif

endmodule

`default_nettype wire

// ----- tb/neighbourhood_outlier_smoother_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Outlier smoother testbench
// Streams frames of gray levels through the block under random back-pressure
// and checks every filtered pixel against a behavioural model of the 3x3
// despeckle window, including frame flushes and register restarts.
// ----------------------------------------------------------------------------

import nos_pkg::*;

// One filtered pixel as it appears on the result channel.
typedef struct packed {
    logic [7:0] data;
    logic       replaced;
    logic       frame_end;
    logic       run_end;
} smoothed_pixel_t;

// Behavioural model of the smoother plus the queue of pixels still owed.
class despeckle_scoreboard;
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [PIX_W-1:0]        upper_row [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]        middle_row [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]        win [3][3];
    int                      col_pos;
    int                      row_pos;
    smoothed_pixel_t         awaited_pixels [$];
    int                      mismatches;

    function void power_on();
        width_reg  = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        thr_reg    = DIFF_THRESHOLD_RST;
        foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        clear_position();
        awaited_pixels.delete();
        mismatches = 0;
    endfunction

    function void clear_position();
        col_pos = 0;
        row_pos = 0;
        foreach (win[i, j]) win[i][j] = '0;
    endfunction

    function int eff_width();
        int w;
        w = width_reg;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH_DEF - 1) w = MAX_WIDTH_DEF - 1;
        return w;
    endfunction

    function int eff_height();
        int h;
        h = height_reg;
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
        return h;
    endfunction

    // Any write to a known register restarts the frame.
    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FRAME_WIDTH:    width_reg  = val[CFG_WIDTH_W-1:0];
            REG_FRAME_HEIGHT:   height_reg = val[CFG_HEIGHT_W-1:0];
            REG_DIFF_THRESHOLD: thr_reg    = val[THR_W-1:0];
            default:            return;
        endcase
        clear_position();
    endfunction

    function void shift_column(logic [PIX_W-1:0] top, logic [PIX_W-1:0] mid,
                               logic [PIX_W-1:0] bot);
        logic [PIX_W-1:0] col [3];
        col[0] = top;
        col[1] = mid;
        col[2] = bot;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
            win[i][2] = col[i];
        end
    endfunction

    // Produce the pixel one row plus one pixel behind position (r, c).
    function bit emit_behind(int r, int c, int w, int h);
        int              orow, ocol, ir, ic, sum, cnt, d;
        logic [PIX_W-1:0] ctr, n, level;
        bit              outlier;
        smoothed_pixel_t res;
        if (r == 0 || (r == 1 && c == 0)) return 1'b0;
        if (c >= 1) begin
            orow = r - 1;
            ocol = c - 1;
        end else begin
            orow = r - 2;
            ocol = w - 1;
        end
        ctr     = win[1][1];
        sum     = ctr;
        cnt     = 1;
        outlier = 1'b1;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                ir = orow + dr - 1;
                ic = ocol + dc - 1;
                if (!(dr == 1 && dc == 1) && ir >= 0 && ir < h && ic >= 0 && ic < w) begin
                    n = win[dr][dc];
                    d = (ctr > n) ? ctr - n : n - ctr;
                    if (d <= thr_reg) outlier = 1'b0;
                    sum += n;
                    cnt++;
                end
            end
        end
        level         = outlier ? 4'((sum / cnt) % 16) : ctr;
        res.data      = {4'b0000, level};
        res.replaced  = outlier;
        res.frame_end = (orow == h - 1 && ocol == w - 1);
        res.run_end   = 1'b0;
        awaited_pixels.push_back(res);
        return 1'b1;
    endfunction

    // Note an accepted input pixel and queue the results it causes.
    function void note_pixel(logic [PIX_W-1:0] p);
        int               w, h, r, c, k;
        logic [PIX_W-1:0] up, md;
        w = eff_width();
        h = eff_height();
        r = row_pos;
        c = col_pos;
        k = 0;
        if (c >= w || r >= h) begin
            r = 0;
            c = 0;
        end
        up = upper_row[c];
        md = middle_row[c];
        shift_column(up, md, p);
        upper_row[c]  = md;
        middle_row[c] = p;
        k += emit_behind(r, c, w, h);
        if (r == h - 1 && c == w - 1) begin
            // Final pixel: drain the two stored rows through the window.
            for (int fc = 0; fc < w; fc++) begin
                shift_column(upper_row[fc], middle_row[fc], 4'd0);
                k += emit_behind(h, fc, w, h);
            end
            shift_column(4'd0, 4'd0, 4'd0);
            k += emit_behind(h + 1, 0, w, h);
            clear_position();
        end else begin
            c++;
            if (c == w) begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r;
        end
        if (k > 0) awaited_pixels[awaited_pixels.size() - 1].run_end = 1'b1;
    endfunction

    function void check_pixel(smoothed_pixel_t got);
        smoothed_pixel_t exp_px;
        if (awaited_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %0h/%0b/%0b/%0b",
                     $time, got.data, got.replaced, got.frame_end, got.run_end);
            return;
        end
        exp_px = awaited_pixels.pop_front();
        if (got !== exp_px) begin
            mismatches++;
            $display("%0t: expected %0h r%0b e%0b l%0b, actual %0h r%0b e%0b l%0b",
                     $time, exp_px.data, exp_px.replaced, exp_px.frame_end, exp_px.run_end,
                     got.data, got.replaced, got.frame_end, got.run_end);
        end
    endfunction
endclass

module neighbourhood_outlier_smoother_test;

    // Cycles allowed for items still inside the pipeline after the last result.
    localparam int LATENCY_WAIT = 8;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT  = 1000;
    // Directed items plus the random part; also paces the idling phases.
    localparam int TOTAL_PIXELS = 210;
    // An index no register answers to; the block must ignore it.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'h00;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   m_tlast;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int send_idle_pct   = 27;
    int recv_idle_pct   = 55;
    int accepted_pixels = 0;
    int quiet_cycles    = 0;

    despeckle_scoreboard sb;

    neighbourhood_outlier_smoother u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver samples the result channel at each rising edge, using the
    // values from before the edge, and picks its ready for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_pixel('{data: m_tdata, replaced: m_tuser[0], frame_end: m_tuser[1],
                             run_end: m_tlast});
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // A hung block shows up as a long run of cycles with no handshake at all.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one pixel and wait until the block takes it. The idling pattern
    // moves through three phases as the run progresses: a slow receiver, then
    // a slow sender, then both at full speed.
    task automatic send_pixel(input logic [PIX_W-1:0] level);
        if (accepted_pixels < TOTAL_PIXELS / 3) begin
            send_idle_pct = 27;
            recv_idle_pct = 55;
        end else if (accepted_pixels < 2 * TOTAL_PIXELS / 3) begin
            send_idle_pct = 55;
            recv_idle_pct = 27;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, level};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(level);
        accepted_pixels++;
    endtask

    // Hold the sender off until every owed result has arrived, then give
    // items that cause no result time to leave the pipeline.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.awaited_pixels.size() != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    // Valid stays high across back-to-back writes; the caller lowers it.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, val);
    endtask

    task automatic configure(input int w, input int h, input int thr, input bit stray);
        if (stray) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_FRAME_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(REG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
        write_reg(REG_DIFF_THRESHOLD, thr[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a smooth background, with speckles at the extremes and some
    // raw noise that also reaches levels above nine.
    function automatic logic [PIX_W-1:0] pick_level(input int bg);
        int roll, lvl;
        roll = $urandom_range(0, 99);
        if (roll < 10) return PIX_W'($urandom_range(0, 15));
        if (roll < 20) return ($urandom_range(0, 1) != 0) ? 4'd9 : 4'd0;
        lvl = bg + int'($urandom_range(0, 2)) - 1;
        if (lvl < 0) lvl = 0;
        if (lvl > 9) lvl = 9;
        return lvl[PIX_W-1:0];
    endfunction

    initial begin
        logic [PIX_W-1:0] corner_seq [8];
        logic [PIX_W-1:0] centre_seq [9];
        logic [PIX_W-1:0] wide_seq [5];
        int w, h, thr, ew, eh, frames, count, bg;

        corner_seq = '{4'd15, 4'd0, 4'd0, 4'd0, 4'd0, 4'd9, 4'd9, 4'd9};
        centre_seq = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0};
        wide_seq   = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd9};

        sb = new;
        sb.power_on();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Widths and heights below two act as two: two 2x2 frames, each of
        // which is all corners, with a zero threshold. The first holds a
        // bright outlier above nine, the second a dark one.
        configure(0, 1, 0, 1'b0);
        foreach (corner_seq[j]) send_pixel(corner_seq[j]);
        wait_drained();

        // A 3x3 frame gives corners, edges and one inner pixel; a stray
        // write to an unused index goes first and must change nothing.
        configure(3, 3, 2, 1'b1);
        foreach (centre_seq[j]) send_pixel(centre_seq[j]);
        wait_drained();

        // Largest register values: width clamps to 31, height to 1024, and
        // the top threshold. Only part of the first row is sent.
        configure(63, 2047, 15, 1'b0);
        foreach (wide_seq[j]) send_pixel(wide_seq[j]);

        // Random part: a fresh setting per phase, then whole frames with
        // random content, now and then broken off early. Frames too big to
        // finish get a partial frame of at most two rows plus three pixels.
        while (accepted_pixels < TOTAL_PIXELS) begin
            wait_drained();
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 1);
                1:       w = $urandom_range(31, 63);
                default: w = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(0, 1);
                1:       h = $urandom_range(1024, 2047);
                default: h = $urandom_range(2, 4);
            endcase
            thr = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 15);
            configure(w, h, thr, $urandom_range(0, 7) == 0);
            ew = sb.eff_width();
            eh = sb.eff_height();
            bg = $urandom_range(0, 9);
            if (ew * eh <= 70) begin
                frames = $urandom_range(1, 3);
                for (int f = 0; f < frames; f++) begin
                    count = ew * eh;
                    if ($urandom_range(0, 9) == 0) count = $urandom_range(1, ew * eh - 1);
                    for (int i = 0; i < count; i++) begin
                        send_pixel(pick_level(bg));
                        // Occasionally let the output side run dry mid-frame.
                        if ($urandom_range(0, 49) == 0) wait_drained();
                    end
                    if (count < ew * eh) break;
                end
            end else begin
                count = $urandom_range(1, 2 * ew + 3);
                for (int i = 0; i < count; i++) send_pixel(pick_level(bg));
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.awaited_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
